@@ rtl/wdo_pkg.sv @@
package wdo_pkg;

   // Default divide width and the fixed width of the operand fields on the ports.
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FIELD_WIDTH    = 32;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] dividend;
      logic [FIELD_WIDTH-1:0] divisor;
      logic                   is_signed;
      logic                   update_overflow;
   } req_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] quotient;
      logic                   overflow_out;
      logic                   summary_overflow_out;
   } rsp_type;

endpackage

@@ rtl/wdo_div.sv @@
module wdo_div #(
   parameter int DATA_WIDTH = wdo_pkg::DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] quotient
);

   localparam int CW = $clog2(DATA_WIDTH + 1);

   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] div_ff, div_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH:0]   diff;

   // One quotient bit per cycle: shift in the next dividend bit, trial subtract.
   assign shifted = {rem_ff, quo_ff[DATA_WIDTH-1]};
   assign diff    = shifted - {1'b0, div_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         div_in = divisor;
         cnt_in = CW'(DATA_WIDTH);
      end else if (cnt_ff != '0) begin
         if (!diff[DATA_WIDTH]) begin
            rem_in = diff[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/word_divide_with_overflow_flags.sv @@
// Word divide with overflow flags.
// Input channel req_*: one beat carries dividend, divisor, the signed/unsigned
// mode bit and the overflow-update bit. Result channel rsp_*: one beat per
// input beat, carrying the quotient and the overflow and summary-overflow flags
// as they stand after that divide. Both channels move a beat when valid is high
// and stall is low.
// Steps from the accepting edge to rsp_valid: operand sign handling, the
// radix-2 restoring divide loop (one quotient bit per cycle), quotient sign
// fix-up and the load of the output register. A zero divisor or
// most-negative / -1 skips the loop. One divide runs at a time and req_stall
// drops the cycle after the output load, so a new request is taken only once
// the last result has left the final stage.
// The output register frees the divider: when rsp_stall holds a finished beat,
// the next request is still taken, and its result waits in the final stage
// until the output register empties.
// Reset (synchronous, active high) clears the flags, drops any divide in
// flight and empties the output register.
module word_divide_with_overflow_flags #(
   parameter int DATA_WIDTH = wdo_pkg::DATA_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  wdo_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output wdo_pkg::rsp_type rsp_data
);

   localparam int W  = DATA_WIDTH;
   localparam int FW = (W > wdo_pkg::FIELD_WIDTH) ? W : wdo_pkg::FIELD_WIDTH;

   localparam logic [W-1:0] MIN_NEG  = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] ALL_ONES = '1;

   // Sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;  // wait for a request
   localparam logic [1:0] ST_PREP = 2'd1;  // classify, take magnitudes
   localparam logic [1:0] ST_DIV  = 2'd2;  // divide loop running
   localparam logic [1:0] ST_DONE = 2'd3;  // result ready, wait for output slot

   logic [1:0]       state_ff, state_in;
   logic [W-1:0]     a_ff, a_in;
   logic [W-1:0]     b_ff, b_in;
   logic             sgn_ff, sgn_in;
   logic             upd_ff, upd_in;
   logic             inv_ff, inv_in;
   logic             neg_ff, neg_in;
   logic [W-1:0]     q_ff, q_in;
   logic             ov_ff, ov_in;
   logic             so_ff, so_in;
   logic             rsp_valid_ff, rsp_valid_in;
   wdo_pkg::rsp_type rsp_ff, rsp_in;

   logic         req_take;
   logic         out_free;
   logic         load_out;
   logic         invalid;
   logic         sa, sb;
   logic [W-1:0] mag_a, mag_b;
   logic [W-1:0] fill;
   logic         core_start;
   logic         core_done;
   logic [W-1:0] core_q;
   logic [FW-1:0] q_wide;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load_out  = (state_ff == ST_DONE) && out_free;

   // Zero divisor, or most negative value over -1 in signed mode.
   assign invalid = (b_ff == '0) || (sgn_ff && (b_ff == ALL_ONES) && (a_ff == MIN_NEG));
   assign sa      = sgn_ff && a_ff[W-1];
   assign sb      = sgn_ff && b_ff[W-1];
   assign mag_a   = sa ? (W'(0) - a_ff) : a_ff;
   assign mag_b   = sb ? (W'(0) - b_ff) : b_ff;
   assign fill    = sa ? ALL_ONES : '0;

   assign core_start = (state_ff == ST_PREP) && !invalid;

   wdo_div #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (core_start),
      .dividend(mag_a),
      .divisor (mag_b),
      .done    (core_done),
      .quotient(core_q)
   );

   assign q_wide = FW'(q_ff);

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      sgn_in       = sgn_ff;
      upd_in       = upd_ff;
      inv_in       = inv_ff;
      neg_in       = neg_ff;
      q_in         = q_ff;
      ov_in        = ov_ff;
      so_in        = so_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      // Drop the output beat once taken; a new load overrides below.
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               // Keep only the low DATA_WIDTH bits of each operand.
               a_in     = W'(req_data.dividend);
               b_in     = W'(req_data.divisor);
               sgn_in   = req_data.is_signed;
               upd_in   = req_data.update_overflow;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            inv_in = invalid;
            neg_in = sa ^ sb;
            if (invalid) begin
               q_in     = fill;
               state_in = ST_DONE;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (core_done) begin
               q_in     = neg_ff ? (W'(0) - core_q) : core_q;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               // Flags advance in result order, so update them at the output load.
               if (upd_ff) begin
                  ov_in = inv_ff;
                  so_in = so_ff | inv_ff;
               end
               rsp_valid_in                = 1'b1;
               rsp_in.quotient             = q_wide[wdo_pkg::FIELD_WIDTH-1:0];
               rsp_in.overflow_out         = upd_ff ? inv_ff : ov_ff;
               rsp_in.summary_overflow_out = upd_ff ? (so_ff | inv_ff) : so_ff;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ov_ff        <= 1'b0;
         so_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ov_ff        <= ov_in;
         so_ff        <= so_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      sgn_ff <= sgn_in;
      upd_ff <= upd_in;
      inv_ff <= inv_in;
      neg_ff <= neg_in;
      q_ff   <= q_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/wdo_check.sv @@
module wdo_check (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input wdo_pkg::rsp_type rsp_data
);

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // Reset empties the output register.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // One divide at a time: a taken request closes the input.
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while divider busy");

   // Overflow never shows without the sticky summary flag.
   a_so_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow_out |-> rsp_data.summary_overflow_out)
      else $error("overflow set without summary overflow");

   // A taken request does not bring a result beat at once when none is showing.
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
      else $error("result appeared too early");

endmodule

bind word_divide_with_overflow_flags wdo_check u_wdo_check (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);
